[design/chd_pkg.sv]
`default_nettype none

package chd_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned LenW    = 6;

  localparam int unsigned MaxTitle  = 64;
  localparam int unsigned LenTop    = (1 << LenW) - 1;
  localparam int unsigned LenCapInt = (MaxTitle - 1 < LenTop) ? MaxTitle - 1 : LenTop;
  localparam logic [LenW-1:0] LenCap = LenW'(LenCapInt);

  localparam logic [OffsetW-1:0] OffsetTop = '1;

  localparam int unsigned ResultSlots = 4;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [UnitW-1:0] UnitLineEnd = 16'h000A;
  localparam logic [UnitW-1:0] UnitSpace   = 16'h0020;
  localparam logic [UnitW-1:0] UnitTab     = 16'h0009;
  localparam logic [UnitW-1:0] UnitIdeoSp  = 16'h3000;
  localparam logic [UnitW-1:0] UnitDi      = 16'h7B2C;
  localparam logic [UnitW-1:0] UnitXie     = 16'h6954;
  localparam logic [UnitW-1:0] UnitZi      = 16'h5B50;
  localparam logic [UnitW-1:0] UnitXu      = 16'h5E8F;
  localparam logic [UnitW-1:0] UnitZhang   = 16'h7AE0;

  typedef enum logic [3:0] {
    PairNone = 4'b0001,
    PairXie  = 4'b0010,
    PairXu   = 4'b0100,
    PairDone = 4'b1000
  } pair_stage_e;

  typedef struct packed {
    logic [OffsetW-1:0] heading_offset;
    logic [LenW-1:0]    title_length;
    logic               last_of_run;
  } chd_result_t;

  typedef struct packed {
    logic [1:0]            cnt;
    chd_result_t [1:0]     res;
  } chd_push_t;

  function automatic logic is_blank(input logic [UnitW-1:0] ch);
    return ch == UnitSpace || ch == UnitTab || ch == UnitIdeoSp;
  endfunction

  function automatic logic is_numeral(input logic [UnitW-1:0] ch);
    logic hit;
    case (ch) inside
      16'h0020, 16'h0009, 16'h3000, 16'h00A0,
      [16'h0030:16'h0039], [16'hFF10:16'hFF19],
      16'h96F6, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB,
      16'h4E94, 16'h516D, 16'h4E03, 16'h516B, 16'h4E5D,
      16'h5341, 16'h767E, 16'h5343, 16'h4E07, 16'h4EBF,
      16'h58F9, 16'h8D30, 16'h53C1, 16'h8086,
      16'h4F0D, 16'h9646, 16'h67D2, 16'h634C, 16'h7396,
      16'h62FE, 16'h4F70, 16'h4EDF, 16'h842C, 16'h5104,
      16'h4E24, 16'h3007: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_unit(input logic [UnitW-1:0] ch);
    logic hit;
    case (ch) inside
      16'h5377, 16'h7AE0, 16'h90E8, 16'h8282, 16'h7BC0,
      16'h56DE, 16'h7BC7, 16'h96C6, 16'h518C,
      16'h5E55, 16'h7F16, 16'h8BDD, 16'h8A71,
      16'h8BB2, 16'h8B1B: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [OffsetW-1:0] sat_back(input logic [OffsetW-1:0] p,
                                                   input logic [1:0] k);
    logic [OffsetW-1:0] kk;
    kk = OffsetW'(k);
    if (p == OffsetTop) return OffsetTop;
    return (p >= kk) ? p - kk : '0;
  endfunction

  function automatic logic [LenW-1:0] capped_len(input logic [OffsetW-1:0] s,
                                                  input logic [OffsetW-1:0] e);
    logic [OffsetW-1:0] diff;
    diff = (e > s) ? e - s : '0;
    return (diff > OffsetW'(LenCapInt)) ? LenCap : diff[LenW-1:0];
  endfunction

endpackage

`default_nettype wire

[design/chd_in_if.sv]
`default_nettype none

interface chd_in_if;
  logic                      valid;
  logic                      ready;
  logic [chd_pkg::UnitW-1:0] code_unit;
  logic                      end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink (input valid, input code_unit, input end_of_text, output ready);
endinterface

`default_nettype wire

[design/chd_out_if.sv]
`default_nettype none

interface chd_out_if;
  logic                        valid;
  logic                        ready;
  logic [chd_pkg::OffsetW-1:0] heading_offset;
  logic [chd_pkg::LenW-1:0]    title_length;
  logic                        last_of_run;

  modport source (output valid, output heading_offset, output title_length,
                  output last_of_run, input ready);
  modport sink (input valid, input heading_offset, input title_length,
                input last_of_run, output ready);
endinterface

`default_nettype wire

[design/chd_result_fifo.sv]
`default_nettype none

module chd_result_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire chd_pkg::chd_push_t push_i,
  output logic                   room_o,
  chd_out_if.source              res_o
);

  chd_pkg::chd_result_t                 mem_q [chd_pkg::FifoDepth];
  logic [chd_pkg::FifoPtrW-1:0]         rd_ptr_q, wr_ptr_q;
  logic [chd_pkg::FifoCntW-1:0]         count_q;
  logic [chd_pkg::FifoPtrW-1:0]         wr_ptr_1;
  logic                                 pop;
  chd_pkg::chd_result_t                 head;

  assign head     = mem_q[rd_ptr_q];
  assign pop      = res_o.valid && res_o.ready;
  assign wr_ptr_1 = wr_ptr_q + chd_pkg::FifoPtrW'(1);
  assign room_o   = count_q <= chd_pkg::FifoCntW'(chd_pkg::FifoDepth - 2);

  assign res_o.valid          = count_q != '0;
  assign res_o.heading_offset = head.heading_offset;
  assign res_o.title_length   = head.title_length;
  assign res_o.last_of_run    = head.last_of_run;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + chd_pkg::FifoPtrW'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + chd_pkg::FifoPtrW'(1);
      end
      count_q <= count_q + chd_pkg::FifoCntW'(push_i.cnt) - chd_pkg::FifoCntW'(pop);
    end
  end

endmodule

`default_nettype wire

[design/chapter_heading_detector_unit.sv]
// Chapter heading detector. Takes one UTF-16 code unit per cycle while the
// result queue has room and reports each heading as its start offset and
// title length once the title end is known. A unit is registered on
// acceptance, then decoded, and its zero, one or two results are written to
// a four-entry result queue; a result reaches the queue output through the
// unit register and then the queue memory. The queue drains one result per
// cycle while the sink is ready; the input stalls only while the queue holds
// more than two results. The state resets after the unit marked end_of_text.
`default_nettype none

module chapter_heading_detector_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chd_in_if.sink     unit_i,
  chd_out_if.source  heading_o
);

  logic                              s1_valid_q;
  logic [chd_pkg::UnitW-1:0]         s1_unit_q;
  logic                              s1_eot_q;
  logic                              s1_adv;
  logic                              in_acc;
  logic                              room;

  logic [chd_pkg::OffsetW-1:0]       position_q, position_d;
  logic                              number_open_q, number_open_d;
  logic [chd_pkg::OffsetW-1:0]       number_start_q, number_start_d;
  logic                              span_all_valid_q, span_all_valid_d;
  logic                              span_has_digit_q, span_has_digit_d;
  chd_pkg::pair_stage_e              pair_stage_q, pair_stage_d;
  logic                              pending_valid_q, pending_valid_d;
  logic [chd_pkg::OffsetW-1:0]       pending_start_q, pending_start_d;

  logic [chd_pkg::ResultSlots-1:0]   slot_v;
  logic [chd_pkg::OffsetW-1:0]       slot_s [chd_pkg::ResultSlots];
  logic [chd_pkg::OffsetW-1:0]       slot_e [chd_pkg::ResultSlots];
  chd_pkg::chd_push_t                push;

  logic                              lf, blank;
  logic [chd_pkg::OffsetW-1:0]       back1, back2, end_c;

  assign s1_adv       = s1_valid_q && room;
  assign unit_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = unit_i.valid && unit_i.ready;

  assign lf    = s1_unit_q == chd_pkg::UnitLineEnd;
  assign blank = chd_pkg::is_blank(s1_unit_q);
  assign back1 = chd_pkg::sat_back(position_q, 2'd1);
  assign back2 = chd_pkg::sat_back(position_q, 2'd2);
  assign end_c = (position_q == chd_pkg::OffsetTop) ? position_q
                                                    : position_q + chd_pkg::OffsetW'(1);

  always_comb begin
    position_d       = position_q;
    number_open_d    = number_open_q;
    number_start_d   = number_start_q;
    span_all_valid_d = span_all_valid_q;
    span_has_digit_d = span_has_digit_q;
    pair_stage_d     = pair_stage_q;
    pending_valid_d  = pending_valid_q;
    pending_start_d  = pending_start_q;
    slot_v           = '0;
    for (int k = 0; k < chd_pkg::ResultSlots; k++) begin
      slot_s[k] = '0;
      slot_e[k] = '0;
    end

    // finish a keyword pair
    unique case (pair_stage_q)
      chd_pkg::PairDone: begin
        if (blank || lf) begin
          slot_v[0]       = pending_valid_d;
          slot_s[0]       = pending_start_d;
          slot_e[0]       = back2;
          pending_valid_d = 1'b1;
          pending_start_d = back2;
        end
        pair_stage_d = chd_pkg::PairNone;
      end
      chd_pkg::PairXie: begin
        pair_stage_d = (s1_unit_q == chd_pkg::UnitZi) ? chd_pkg::PairDone : chd_pkg::PairNone;
      end
      chd_pkg::PairXu: begin
        pair_stage_d = (s1_unit_q == chd_pkg::UnitZhang) ? chd_pkg::PairDone
                                                         : chd_pkg::PairNone;
      end
      default: begin
        pair_stage_d = chd_pkg::PairNone;
      end
    endcase

    if (lf) begin
      slot_v[1]       = pending_valid_d;
      slot_s[1]       = pending_start_d;
      slot_e[1]       = position_q;
      pending_valid_d = 1'b0;
      number_open_d   = 1'b0;
      pair_stage_d    = chd_pkg::PairNone;
    end else if (s1_unit_q == chd_pkg::UnitDi) begin
      number_open_d    = 1'b1;
      number_start_d   = position_q;
      span_all_valid_d = 1'b1;
      span_has_digit_d = 1'b0;
    end else if (number_open_q && span_all_valid_q && span_has_digit_q &&
                 chd_pkg::is_unit(s1_unit_q)) begin
      slot_v[1]       = pending_valid_d;
      slot_s[1]       = pending_start_d;
      slot_e[1]       = number_start_q;
      pending_valid_d = 1'b1;
      pending_start_d = number_start_q;
      number_open_d   = 1'b0;
    end else if (number_open_q) begin
      if (!chd_pkg::is_numeral(s1_unit_q)) begin
        span_all_valid_d = 1'b0;
      end else if (!blank) begin
        span_has_digit_d = 1'b1;
      end
    end else if (pair_stage_d == chd_pkg::PairNone) begin
      if (s1_unit_q == chd_pkg::UnitXie) begin
        pair_stage_d = chd_pkg::PairXie;
      end else if (s1_unit_q == chd_pkg::UnitXu) begin
        pair_stage_d = chd_pkg::PairXu;
      end
    end

    // close the text
    if (s1_eot_q) begin
      if (!lf) begin
        if (pair_stage_d == chd_pkg::PairDone) begin
          slot_v[2]       = pending_valid_d;
          slot_s[2]       = pending_start_d;
          slot_e[2]       = back1;
          pending_valid_d = 1'b1;
          pending_start_d = back1;
        end
        slot_v[3] = pending_valid_d;
        slot_s[3] = pending_start_d;
        slot_e[3] = end_c;
      end
      position_d       = '0;
      number_open_d    = 1'b0;
      number_start_d   = '0;
      span_all_valid_d = 1'b0;
      span_has_digit_d = 1'b0;
      pair_stage_d     = chd_pkg::PairNone;
      pending_valid_d  = 1'b0;
      pending_start_d  = '0;
    end else if (position_q != chd_pkg::OffsetTop) begin
      position_d = position_q + chd_pkg::OffsetW'(1);
    end
  end

  // pack up to two results in order
  always_comb begin
    push = '0;
    for (int k = 0; k < chd_pkg::ResultSlots; k++) begin
      if (slot_v[k]) begin
        if (push.cnt == 2'd0) begin
          push.res[0].heading_offset = slot_s[k];
          push.res[0].title_length   = chd_pkg::capped_len(slot_s[k], slot_e[k]);
          push.cnt                   = 2'd1;
        end else if (push.cnt == 2'd1) begin
          push.res[1].heading_offset = slot_s[k];
          push.res[1].title_length   = chd_pkg::capped_len(slot_s[k], slot_e[k]);
          push.cnt                   = 2'd2;
        end
      end
    end
    push.res[0].last_of_run = push.cnt == 2'd1;
    push.res[1].last_of_run = push.cnt == 2'd2;
    if (!s1_adv) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_unit_q <= unit_i.code_unit;
      s1_eot_q  <= unit_i.end_of_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      position_q       <= '0;
      number_open_q    <= 1'b0;
      number_start_q   <= '0;
      span_all_valid_q <= 1'b0;
      span_has_digit_q <= 1'b0;
      pair_stage_q     <= chd_pkg::PairNone;
      pending_valid_q  <= 1'b0;
      pending_start_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        position_q       <= position_d;
        number_open_q    <= number_open_d;
        number_start_q   <= number_start_d;
        span_all_valid_q <= span_all_valid_d;
        span_has_digit_q <= span_has_digit_d;
        pair_stage_q     <= pair_stage_d;
        pending_valid_q  <= pending_valid_d;
        pending_start_q  <= pending_start_d;
      end
    end
  end

  chd_result_fifo u_result_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (heading_o)
  );

`ifndef ASSERT_OFF
  a_eot_resets_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_eot_q |=> position_q == '0)
    else $error("position not cleared after end of text");

  a_line_end_drops_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && lf |=> !pending_valid_q && !number_open_q)
    else $error("heading state survives a line end");

  a_position_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_q == chd_pkg::OffsetTop && !(s1_adv && s1_eot_q) |=>
      position_q == chd_pkg::OffsetTop)
    else $error("position wrapped");

  a_number_excludes_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(number_open_q && pair_stage_q != chd_pkg::PairNone))
    else $error("keyword pair tracked inside an open number");
`endif

endmodule

`default_nettype wire
